// File: hw/rtl/nrs_pkg.sv
`default_nettype none

package nrs_pkg;

   // operation codes on req_operation
   localparam logic OP_ARM  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [14:0] FULL_Q15     = 15'h7fff;
   localparam logic [15:0] FADE_TOP     = 16'd32766;  // fade for a knob of zero
   localparam logic [7:0]  MIN_PER_RST  = 8'd6;
   localparam int          DIV_STEPS    = 8;          // two quotient bits per step
   localparam int          DIV_CNT_W    = $clog2(DIV_STEPS);

   // controller to datapath
   typedef struct packed {
      logic arm;        // load state from an arm transfer
      logic tick;       // apply one pulse tick
      logic div_start;  // load the divider
      logic div_step;   // advance the divider by two bits
      logic div_done;   // last divider step, commit the step value
      logic publish;    // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_is_tick;
      logic arm_needs_div;
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/note_retrigger_scheduler_core.sv
`default_nettype none

// channel  direction  handshake              payload
// req      in         req_valid / req_ready  operation, length/speed/fade knobs, voice_present
// rsp      out        rsp_valid / rsp_ready  strike, strikes_left, start_volume, volume_step
// csr      in         csr_valid / csr_ready  csr_data -> min_period
//
// A tick, or an arm with a zero length, has its result valid in the cycle after
// its transfer. An arm with strikes gets its signed step from a restoring divider
// that resolves two quotient bits per cycle; the result is registered with the
// last step. One item is in work at a time; a new request is taken when idle and
// the result register is empty or being drained. Synchronous reset sets min_period
// to 6 and clears all but the divider and result registers. csr_ready is always high.

module note_retrigger_scheduler_core (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire                req_operation,
   input  wire  [7:0]         req_length_knob,
   input  wire  [7:0]         req_speed_knob,
   input  wire  [7:0]         req_fade_knob,
   input  wire                req_voice_present,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic               rsp_strike,
   output logic [2:0]         rsp_strikes_left,
   output logic [14:0]        rsp_start_volume,
   output logic signed [15:0] rsp_volume_step,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [7:0]         csr_data
);

   nrs_pkg::cmd_type    cmd;
   nrs_pkg::status_type status;

   assign csr_ready = 1'b1;

   nrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nrs_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_valid && csr_ready),
      .csr_data          (csr_data),
      .req_operation     (req_operation),
      .req_length_knob   (req_length_knob),
      .req_speed_knob    (req_speed_knob),
      .req_fade_knob     (req_fade_knob),
      .req_voice_present (req_voice_present),
      .rsp_strike        (rsp_strike),
      .rsp_strikes_left  (rsp_strikes_left),
      .rsp_start_volume  (rsp_start_volume),
      .rsp_volume_step   (rsp_volume_step)
   );

endmodule

`default_nettype wire

// File: hw/rtl/nrs_ctrl.sv
`default_nettype none

module nrs_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   input  nrs_pkg::status_type status,
   output nrs_pkg::cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_DIVIDE = 2'b10
   } state_type;

   state_type                       state_ff, state_in;
   logic [nrs_pkg::DIV_CNT_W-1:0]   iter_ff, iter_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            take;

   // accept only when idle and the result register is free by the same edge
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // sequence one item
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (status.req_is_tick) begin
                  cmd.tick    = 1'b1;
                  cmd.publish = 1'b1;
               end else begin
                  cmd.arm = 1'b1;
                  if (status.arm_needs_div) begin
                     cmd.div_start = 1'b1;
                     iter_in       = '0;
                     state_in      = ST_DIVIDE;
                  end else begin
                     cmd.publish = 1'b1;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + 1'b1;
            if (iter_ff == nrs_pkg::DIV_CNT_W'(nrs_pkg::DIV_STEPS - 1)) begin
               cmd.div_done = 1'b1;
               cmd.publish  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold the result until its transfer
   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/nrs_dpath.sv
`default_nettype none

module nrs_dpath (
   input  wire                clock,
   input  wire                reset,
   input  nrs_pkg::cmd_type   cmd,
   output nrs_pkg::status_type status,
   input  wire                csr_write,
   input  wire  [7:0]         csr_data,
   input  wire                req_operation,
   input  wire  [7:0]         req_length_knob,
   input  wire  [7:0]         req_speed_knob,
   input  wire  [7:0]         req_fade_knob,
   input  wire                req_voice_present,
   output logic               rsp_strike,
   output logic [2:0]         rsp_strikes_left,
   output logic [14:0]        rsp_start_volume,
   output logic signed [15:0] rsp_volume_step
);

   logic [7:0]  min_period_ff;
   logic [2:0]  count_ff, count_in;
   logic [7:0]  countdown_ff, countdown_in;
   logic [14:0] volume_ff, volume_in;
   logic [15:0] step_ff, step_in;
   logic        fire;

   logic [15:0] quot_ff, quot_in;
   logic [2:0]  rem_ff, rem_in;
   logic        sign_ff;

   logic [4:0]  speed_per;
   logic [7:0]  period;
   logic [15:0] fade;
   logic [15:0] fade_mag;
   logic [7:0]  cd_dec;
   logic [3:0]  r1, r2;
   logic        ge1, ge2;
   logic [2:0]  r1s;

   assign status.req_is_tick   = (req_operation == nrs_pkg::OP_TICK);
   assign status.arm_needs_div = (req_length_knob[7:5] != 3'd0);

   // period from the speed knob, floored at the configured minimum
   assign speed_per = {req_speed_knob[7:5], 2'b00};
   assign period    = ({3'b000, speed_per} < min_period_ff) ? min_period_ff
                                                            : {3'b000, speed_per};

   // fade = 32766 - 256 * knob, negative when the knob's top bit is set
   assign fade     = nrs_pkg::FADE_TOP - {req_fade_knob, 8'h00};
   assign fade_mag = req_fade_knob[7] ? 16'(~fade + 16'd1) : fade;

   assign cd_dec = (countdown_ff != 8'd0) ? countdown_ff - 8'd1 : 8'd0;

   // two restoring divide steps per cycle against the strike count
   assign r1  = {rem_ff, quot_ff[15]};
   assign ge1 = (r1 >= {1'b0, count_ff});
   assign r1s = ge1 ? 3'(r1 - {1'b0, count_ff}) : r1[2:0];
   assign r2  = {r1s, quot_ff[14]};
   assign ge2 = (r2 >= {1'b0, count_ff});

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (cmd.div_start) begin
         quot_in = fade_mag;
         rem_in  = 3'd0;
      end else if (cmd.div_step) begin
         quot_in = {quot_ff[13:0], ge1, ge2};
         rem_in  = ge2 ? 3'(r2 - {1'b0, count_ff}) : r2[2:0];
      end
   end

   // next scheduler state
   always_comb begin
      count_in     = count_ff;
      countdown_in = countdown_ff;
      volume_in    = volume_ff;
      step_in      = step_ff;
      fire         = 1'b0;
      if (cmd.arm) begin
         count_in     = req_length_knob[7:5];
         countdown_in = period;
         if (req_length_knob[7:5] == 3'd0) begin
            volume_in = nrs_pkg::FULL_Q15;
            step_in   = 16'd0;
         end else if (!req_fade_knob[7]) begin
            volume_in = {req_fade_knob[6:0], 8'h01};
         end else begin
            volume_in = nrs_pkg::FULL_Q15;
         end
      end
      if (cmd.tick && count_ff != 3'd0 && req_voice_present) begin
         countdown_in = cd_dec;
         if (cd_dec == 8'd0) begin
            fire         = 1'b1;
            count_in     = count_ff - 3'd1;
            countdown_in = period;
         end
      end
      if (cmd.div_done) begin
         step_in = sign_ff ? 16'(~quot_in + 16'd1) : quot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= nrs_pkg::MIN_PER_RST;
         count_ff      <= '0;
         countdown_ff  <= '0;
         volume_ff     <= '0;
         step_ff       <= '0;
      end else begin
         if (csr_write) begin
            min_period_ff <= csr_data;
         end
         count_ff     <= count_in;
         countdown_ff <= countdown_in;
         volume_ff    <= volume_in;
         step_ff      <= step_in;
      end
   end

   // divider and result registers
   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (cmd.div_start) begin
         sign_ff <= req_fade_knob[7];
      end
      if (cmd.publish) begin
         rsp_strike       <= fire;
         rsp_strikes_left <= count_in;
         rsp_start_volume <= volume_in;
         rsp_volume_step  <= step_in;
      end
   end

endmodule

`default_nettype wire
